// File: sv/tbp_pkg.sv
package tbp_pkg;

    localparam int unsigned LIMIT_W = 16;
    localparam int unsigned S_DATA_W = 16;
    localparam int unsigned S_USER_W = 3;
    localparam int unsigned M_DATA_W = 32;

    localparam logic [7:0] STARTUP_TICKS = 8'd62;
    localparam logic [7:0] STARTUP_RELOAD = 8'd255;
    localparam logic [2:0] WATCHDOG_TICKS = 3'd4;
    localparam logic [7:0] IDLE_BYTE = 8'hff;
    localparam logic [7:0] NULL_BYTE = 8'h00;
    localparam logic [LIMIT_W-1:0] TRIP_LIMIT_RESET = 16'd4300;
    localparam logic [15:0] COUNT_MAX = 16'hffff;

    typedef enum logic [2:0] {
        OP_PULSE      = 3'd0,
        OP_WINDOW_END = 3'd1,
        OP_POWER_REQ  = 3'd2,
        OP_PACKET     = 3'd3,
        OP_TICK       = 3'd4,
        OP_CUTOUT_TMR = 3'd5,
        OP_READ_PEAK  = 3'd6,
        OP_NOP        = 3'd7
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_ESTOP   = 2'd1,
        ST_UNKNOWN = 2'd2,
        ST_RSVD    = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        BR_OFF    = 2'd0,
        BR_FOLLOW = 2'd1,
        BR_CUTOUT = 2'd2,
        BR_RSVD   = 2'd3
    } bridge_t;

    typedef enum logic [1:0] {
        CO_NONE     = 2'd0,
        CO_PENDING  = 2'd1,
        CO_ACTIVE   = 2'd2,
        CO_RECOVERY = 2'd3
    } cutout_t;

    // Packed so that the first field lands in the highest bits.
    typedef struct packed {
        logic [7:0] lead_byte;
        logic       from_broadcast;
        logic       turn_on;
        opcode_t    opcode;
    } item_t;

    typedef struct packed {
        cutout_t     cutout_stage;
        logic [15:0] peak_count;
        bridge_t     bridge_mode;
        logic        sensing;
        logic        trip_flag;
        logic        estop_flag;
        logic        power_flag;
        status_t     status;
    } result_t;

endpackage

// File: sv/track_booster_protection.sv
// Channel   Ports                          Contents
// input     s_tvalid s_tready s_tuser      tuser: opcode; tdata: turn_on, from_broadcast,
//           s_tdata                        lead_byte
// result    m_tvalid m_tready m_tdata      tdata: status .. cutout_stage (26 bits used)
// config    cfg_we cfg_wdata               trip_limit, taken if cfg_we high, not in reset
//
// One item per clock while the result register drains. An item is held in the input
// register, evaluated against the state in a single pass and loaded into the result
// register, which presents it until it leaves with m_tready high.
// Reset is synchronous and active low; it clears the state and sets trip_limit to 4300.
// A stalled result register holds its item; the input register keeps taking
// items as long as the result register drains.
module track_booster_protection (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [tbp_pkg::LIMIT_W-1:0]     cfg_wdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [tbp_pkg::S_USER_W-1:0]    s_tuser,   // [2:0] opcode
    input  logic [tbp_pkg::S_DATA_W-1:0]    s_tdata,   // [0] turn_on, [1] from_broadcast,
                                                       // [9:2] lead_byte
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [tbp_pkg::M_DATA_W-1:0]    m_tdata    // [1:0] status, [2] power_flag,
                                                       // [3] estop_flag, [4] trip_flag,
                                                       // [5] sensing, [7:6] bridge_mode,
                                                       // [23:8] peak_count,
                                                       // [25:24] cutout_stage
);

    logic             item_valid;
    tbp_pkg::item_t   item;
    tbp_pkg::result_t result;
    logic             out_busy;
    logic             advance;

    assign advance = item_valid && !out_busy;

    tbp_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tuser    (s_tuser),
        .s_tdata    (s_tdata),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    tbp_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .advance   (advance),
        .item      (item),
        .result    (result)
    );

    tbp_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (advance),
        .result   (result),
        .busy     (out_busy),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// File: sv/tbp_in_stage.sv
module tbp_in_stage (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [tbp_pkg::S_USER_W-1:0]    s_tuser,
    input  logic [tbp_pkg::S_DATA_W-1:0]    s_tdata,
    input  logic                            advance,
    output logic                            item_valid,
    output tbp_pkg::item_t                  item
);

    logic           valid_reg;
    tbp_pkg::item_t item_reg;

    assign s_tready   = !valid_reg || advance;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
        if (s_tvalid && s_tready) begin
            item_reg.opcode         <= tbp_pkg::opcode_t'(s_tuser);
            item_reg.turn_on        <= s_tdata[0];
            item_reg.from_broadcast <= s_tdata[1];
            item_reg.lead_byte      <= s_tdata[9:2];
        end
    end

endmodule

// File: sv/tbp_core.sv
module tbp_core (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [tbp_pkg::LIMIT_W-1:0]      cfg_wdata,
    input  logic                             advance,
    input  tbp_pkg::item_t                   item,
    output tbp_pkg::result_t                 result
);

    typedef struct packed {
        logic              on_bit;
        logic              estop_bit;
        logic              trip_bit;
        logic              track_driven;
        logic              sense_on;
        logic [15:0]       pulse_count;
        logic [15:0]       pulse_peak;
        logic [7:0]        startup_left;
        logic              startup_over;
        logic [2:0]        watchdog_left;
        tbp_pkg::cutout_t  cutout_now;
    } state_t;

    state_t                         st_reg;
    state_t                         st_next;
    logic [tbp_pkg::LIMIT_W-1:0]    limit_reg;
    tbp_pkg::status_t               status;
    logic                           power_off;

    always_comb begin
        st_next   = st_reg;
        status    = tbp_pkg::ST_OK;
        power_off = 1'b0;

        case (item.opcode)
            tbp_pkg::OP_PULSE: begin
                if (st_reg.sense_on) begin
                    if (st_reg.pulse_count <= limit_reg &&
                        st_reg.pulse_count != tbp_pkg::COUNT_MAX) begin
                        st_next.pulse_count = st_reg.pulse_count + 16'd1;
                    end
                    if (st_next.pulse_count > st_reg.pulse_peak) begin
                        st_next.pulse_peak = st_next.pulse_count;
                    end
                end
            end
            tbp_pkg::OP_WINDOW_END: begin
                if (st_reg.track_driven) begin
                    if (st_reg.pulse_count >= limit_reg) begin
                        power_off        = 1'b1;
                        st_next.trip_bit = 1'b1;
                    end
                    st_next.pulse_count = 16'd0;
                end
            end
            tbp_pkg::OP_POWER_REQ: begin
                if (item.from_broadcast) begin
                    status = tbp_pkg::ST_UNKNOWN;
                end else if (item.turn_on) begin
                    if (st_reg.estop_bit) begin
                        status = tbp_pkg::ST_ESTOP;
                    end else begin
                        if (!st_reg.on_bit) begin
                            st_next.track_driven  = 1'b1;
                            st_next.trip_bit      = 1'b0;
                            st_next.sense_on      = 1'b0;
                            st_next.pulse_count   = 16'd0;
                            st_next.startup_left  = tbp_pkg::STARTUP_TICKS;
                            st_next.startup_over  = 1'b0;
                            st_next.watchdog_left = tbp_pkg::WATCHDOG_TICKS;
                        end
                        st_next.on_bit = 1'b1;
                    end
                end else begin
                    power_off         = 1'b1;
                    st_next.on_bit    = 1'b0;
                    st_next.estop_bit = 1'b0;
                end
            end
            tbp_pkg::OP_PACKET: begin
                if (st_reg.track_driven) begin
                    st_next.watchdog_left = tbp_pkg::WATCHDOG_TICKS;
                    if (item.lead_byte != tbp_pkg::NULL_BYTE &&
                        item.lead_byte != tbp_pkg::IDLE_BYTE) begin
                        st_next.cutout_now = tbp_pkg::CO_PENDING;
                    end
                end
            end
            tbp_pkg::OP_TICK: begin
                if (st_reg.startup_left <= 8'd1) begin
                    st_next.startup_left = tbp_pkg::STARTUP_RELOAD;
                    if (st_reg.track_driven) begin
                        st_next.startup_over = 1'b1;
                        st_next.sense_on     = 1'b1;
                    end
                end else begin
                    st_next.startup_left = st_reg.startup_left - 8'd1;
                end
                if (st_reg.watchdog_left != 3'd0) begin
                    st_next.watchdog_left = st_reg.watchdog_left - 3'd1;
                end
                // The watchdog trips on the value after this tick's decrement.
                if (st_reg.on_bit && st_next.watchdog_left == 3'd0) begin
                    power_off         = 1'b1;
                    st_next.estop_bit = 1'b1;
                    st_next.on_bit    = 1'b0;
                end
            end
            tbp_pkg::OP_CUTOUT_TMR: begin
                case (st_reg.cutout_now)
                    tbp_pkg::CO_PENDING: begin
                        st_next.cutout_now = tbp_pkg::CO_ACTIVE;
                        st_next.sense_on   = 1'b0;
                    end
                    tbp_pkg::CO_ACTIVE: begin
                        st_next.cutout_now = tbp_pkg::CO_RECOVERY;
                    end
                    tbp_pkg::CO_RECOVERY: begin
                        st_next.cutout_now = tbp_pkg::CO_NONE;
                        if (st_reg.startup_over) begin
                            st_next.sense_on = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            tbp_pkg::OP_READ_PEAK: begin
                st_next.pulse_peak = 16'd0;
            end
            default: begin
            end
        endcase

        if (power_off) begin
            st_next.sense_on     = 1'b0;
            st_next.pulse_count  = 16'd0;
            st_next.track_driven = 1'b0;
            st_next.startup_left = tbp_pkg::STARTUP_RELOAD;
            st_next.startup_over = 1'b0;
            st_next.cutout_now   = tbp_pkg::CO_NONE;
        end

        result.status       = status;
        result.power_flag   = st_next.on_bit;
        result.estop_flag   = st_next.estop_bit;
        result.trip_flag    = st_next.trip_bit;
        result.sensing      = st_next.sense_on;
        result.cutout_stage = st_next.cutout_now;
        // A peak read reports the value held before it is cleared.
        result.peak_count   = (item.opcode == tbp_pkg::OP_READ_PEAK) ?
                              st_reg.pulse_peak : st_next.pulse_peak;
        if (!st_next.track_driven) begin
            result.bridge_mode = tbp_pkg::BR_OFF;
        end else if (st_next.cutout_now == tbp_pkg::CO_ACTIVE) begin
            result.bridge_mode = tbp_pkg::BR_CUTOUT;
        end else begin
            result.bridge_mode = tbp_pkg::BR_FOLLOW;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg           <= tbp_pkg::TRIP_LIMIT_RESET;
            st_reg.on_bit        <= 1'b0;
            st_reg.estop_bit     <= 1'b0;
            st_reg.trip_bit      <= 1'b0;
            st_reg.track_driven  <= 1'b0;
            st_reg.sense_on      <= 1'b0;
            st_reg.pulse_count   <= 16'd0;
            st_reg.pulse_peak    <= 16'd0;
            st_reg.startup_left  <= tbp_pkg::STARTUP_RELOAD;
            st_reg.startup_over  <= 1'b0;
            st_reg.watchdog_left <= 3'd0;
            st_reg.cutout_now    <= tbp_pkg::CO_NONE;
        end else begin
            if (cfg_we) begin
                limit_reg <= cfg_wdata;
            end
            if (advance) begin
                st_reg <= st_next;
            end
        end
    end

endmodule

// File: sv/tbp_out_stage.sv
module tbp_out_stage (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            load,
    input  tbp_pkg::result_t                result,
    output logic                            busy,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [tbp_pkg::M_DATA_W-1:0]    m_tdata
);

    logic             valid_reg;
    tbp_pkg::result_t result_reg;

    // The register can take a new item when empty or when its item leaves now.
    assign busy     = valid_reg && !m_tready;
    assign m_tvalid = valid_reg;
    assign m_tdata  = tbp_pkg::M_DATA_W'(result_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
        if (load) begin
            result_reg <= result;
        end
    end

endmodule

// File: sv/tbp_checker.sv
module tbp_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [tbp_pkg::M_DATA_W-1:0]    m_tdata
);

    // A stalled result stays in place.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Nothing is left over from before reset.
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // Emergency stop always comes with the booster switched off.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[2] && m_tdata[3]))
        else $error("power and emergency stop both set");

    // Both low sides are only switched on in the cutout stage proper.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[7:6] == 2'd2 |-> m_tdata[25:24] == 2'd2)
        else $error("cutout bridge mode outside cutout stage");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[1:0] != 2'd3 && m_tdata[7:6] != 2'd3)
        else $error("unused status or bridge code");

endmodule

bind track_booster_protection tbp_checker u_tbp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int unsigned STALL_LIMIT = 2000;
    localparam int unsigned PHASE_ITEMS = 110;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned NUM_PHASES = 5;

    class booster_scoreboard;
        logic [tbp_pkg::LIMIT_W-1:0] trip_limit;
        logic                        powered;
        logic                        estop_latched;
        logic                        tripped;
        logic                        driven;
        logic                        sense_en;
        logic                        startup_done;
        logic [15:0]                 pulses;
        logic [15:0]                 peak;
        logic [7:0]                  startup_left;
        logic [2:0]                  wdog_left;
        tbp_pkg::cutout_t            cutout;
        tbp_pkg::result_t            status_due[$];
        int unsigned                 errors;
        int unsigned                 events_seen;
        int unsigned                 results_seen;
        int unsigned                 trips;
        int unsigned                 estops;
        int unsigned                 cutouts;

        function new();
            trip_limit = tbp_pkg::TRIP_LIMIT_RESET;
            powered = 1'b0;
            estop_latched = 1'b0;
            tripped = 1'b0;
            driven = 1'b0;
            sense_en = 1'b0;
            startup_done = 1'b0;
            pulses = '0;
            peak = '0;
            startup_left = tbp_pkg::STARTUP_RELOAD;
            wdog_left = '0;
            cutout = tbp_pkg::CO_NONE;
            errors = 0;
            events_seen = 0;
            results_seen = 0;
            trips = 0;
            estops = 0;
            cutouts = 0;
        endfunction

        function void drop_track();
            sense_en = 1'b0;
            pulses = '0;
            driven = 1'b0;
            startup_left = tbp_pkg::STARTUP_RELOAD;
            startup_done = 1'b0;
            cutout = tbp_pkg::CO_NONE;
        endfunction

        function void raise_track();
            driven = 1'b1;
            tripped = 1'b0;
            sense_en = 1'b0;
            pulses = '0;
            startup_left = tbp_pkg::STARTUP_TICKS;
            startup_done = 1'b0;
            wdog_left = tbp_pkg::WATCHDOG_TICKS;
        endfunction

        // Applies one accepted item to the booster state and queues the status it must report.
        function void note_event(tbp_pkg::item_t it);
            tbp_pkg::result_t r;
            tbp_pkg::status_t st;
            logic [15:0]      shown_peak;
            st = tbp_pkg::ST_OK;
            events_seen++;
            case (it.opcode)
                tbp_pkg::OP_PULSE: begin
                    if (sense_en) begin
                        if (pulses <= trip_limit && pulses != tbp_pkg::COUNT_MAX)
                            pulses = pulses + 16'd1;
                        if (pulses > peak)
                            peak = pulses;
                    end
                end
                tbp_pkg::OP_WINDOW_END: begin
                    if (driven) begin
                        if (pulses >= trip_limit) begin
                            drop_track();
                            tripped = 1'b1;
                            trips++;
                        end
                        pulses = '0;
                    end
                end
                tbp_pkg::OP_POWER_REQ: begin
                    if (it.from_broadcast) begin
                        st = tbp_pkg::ST_UNKNOWN;
                    end else if (it.turn_on) begin
                        if (estop_latched) begin
                            st = tbp_pkg::ST_ESTOP;
                        end else begin
                            if (!powered)
                                raise_track();
                            powered = 1'b1;
                        end
                    end else begin
                        drop_track();
                        powered = 1'b0;
                        estop_latched = 1'b0;
                    end
                end
                tbp_pkg::OP_PACKET: begin
                    if (driven) begin
                        wdog_left = tbp_pkg::WATCHDOG_TICKS;
                        if (it.lead_byte != tbp_pkg::NULL_BYTE &&
                            it.lead_byte != tbp_pkg::IDLE_BYTE)
                            cutout = tbp_pkg::CO_PENDING;
                    end
                end
                tbp_pkg::OP_TICK: begin
                    if (startup_left <= 8'd1) begin
                        startup_left = tbp_pkg::STARTUP_RELOAD;
                        if (driven) begin
                            startup_done = 1'b1;
                            sense_en = 1'b1;
                        end
                    end else begin
                        startup_left = startup_left - 8'd1;
                    end
                    if (wdog_left != 3'd0)
                        wdog_left = wdog_left - 3'd1;
                    if (powered && wdog_left == 3'd0) begin
                        drop_track();
                        estop_latched = 1'b1;
                        powered = 1'b0;
                        estops++;
                    end
                end
                tbp_pkg::OP_CUTOUT_TMR: begin
                    case (cutout)
                        tbp_pkg::CO_PENDING: begin
                            cutout = tbp_pkg::CO_ACTIVE;
                            sense_en = 1'b0;
                            cutouts++;
                        end
                        tbp_pkg::CO_ACTIVE: begin
                            cutout = tbp_pkg::CO_RECOVERY;
                        end
                        tbp_pkg::CO_RECOVERY: begin
                            cutout = tbp_pkg::CO_NONE;
                            if (startup_done)
                                sense_en = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
                default: begin
                end
            endcase

            shown_peak = peak;
            if (it.opcode == tbp_pkg::OP_READ_PEAK)
                peak = '0;

            r.status = st;
            r.power_flag = powered;
            r.estop_flag = estop_latched;
            r.trip_flag = tripped;
            r.sensing = sense_en;
            if (!driven)
                r.bridge_mode = tbp_pkg::BR_OFF;
            else if (cutout == tbp_pkg::CO_ACTIVE)
                r.bridge_mode = tbp_pkg::BR_CUTOUT;
            else
                r.bridge_mode = tbp_pkg::BR_FOLLOW;
            r.peak_count = shown_peak;
            r.cutout_stage = cutout;
            status_due.push_back(r);
        endfunction

        task report_mismatch(string what, logic [15:0] got, logic [15:0] want);
            errors++;
            $display("MISMATCH at %0t ns: %s got %0d expected %0d", $time, what, got, want);
        endtask

        task check_status(logic [tbp_pkg::M_DATA_W-1:0] word);
            tbp_pkg::result_t got;
            tbp_pkg::result_t want;
            got = word[$bits(tbp_pkg::result_t)-1:0];
            results_seen++;
            if (status_due.size() == 0) begin
                report_mismatch("result with nothing expected, low bits", word[15:0], '0);
                return;
            end
            want = status_due.pop_front();
            if (got.status !== want.status)
                report_mismatch("status", 16'(got.status), 16'(want.status));
            if (got.power_flag !== want.power_flag)
                report_mismatch("power_flag", 16'(got.power_flag), 16'(want.power_flag));
            if (got.estop_flag !== want.estop_flag)
                report_mismatch("estop_flag", 16'(got.estop_flag), 16'(want.estop_flag));
            if (got.trip_flag !== want.trip_flag)
                report_mismatch("trip_flag", 16'(got.trip_flag), 16'(want.trip_flag));
            if (got.sensing !== want.sensing)
                report_mismatch("sensing", 16'(got.sensing), 16'(want.sensing));
            if (got.bridge_mode !== want.bridge_mode)
                report_mismatch("bridge_mode", 16'(got.bridge_mode), 16'(want.bridge_mode));
            if (got.peak_count !== want.peak_count)
                report_mismatch("peak_count", got.peak_count, want.peak_count);
            if (got.cutout_stage !== want.cutout_stage)
                report_mismatch("cutout_stage", 16'(got.cutout_stage),
                                16'(want.cutout_stage));
        endtask

        task finish_check();
            if (status_due.size() != 0)
                report_mismatch("results never delivered", 16'(status_due.size()), '0);
        endtask
    endclass

    logic                           aclk;
    logic                           aresetn;
    logic                           cfg_we;
    logic [tbp_pkg::LIMIT_W-1:0]    cfg_wdata;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [tbp_pkg::S_USER_W-1:0]   s_tuser;
    logic [tbp_pkg::S_DATA_W-1:0]   s_tdata;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [tbp_pkg::M_DATA_W-1:0]   m_tdata;

    booster_scoreboard board;
    int unsigned send_idle_pct = 20;
    int unsigned recv_idle_pct = 45;
    int unsigned sent_items = 0;
    int unsigned stall_cycles = 0;

    track_booster_protection dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            m_tready = ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            board.check_status(m_tdata);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("track_booster_protection verification failed");
        $finish;
    end

    task automatic drain_results();
        s_tvalid = 1'b0;
        while (board.status_due.size() != 0)
            @(negedge aclk);
    endtask

    // Called just after a falling edge; returns just after the falling edge that follows acceptance.
    task automatic send_item(input tbp_pkg::item_t it);
        if ($urandom_range(0, 99) == 0)
            drain_results();
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser = it.opcode;
        s_tdata = tbp_pkg::S_DATA_W'({it.lead_byte, it.from_broadcast, it.turn_on});
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        board.note_event(it);
        sent_items++;
        @(negedge aclk);
    endtask

    function automatic tbp_pkg::item_t rand_item(input tbp_pkg::opcode_t op);
        tbp_pkg::item_t it;
        int unsigned    pick;
        pick = $urandom_range(0, 9);
        it.opcode = op;
        it.turn_on = 1'($urandom_range(0, 1));
        it.from_broadcast = ($urandom_range(0, 6) == 0);
        if (pick == 0)
            it.lead_byte = tbp_pkg::NULL_BYTE;
        else if (pick == 1)
            it.lead_byte = tbp_pkg::IDLE_BYTE;
        else
            it.lead_byte = 8'($urandom_range(0, 255));
        return it;
    endfunction

    task automatic send_op(input tbp_pkg::opcode_t op);
        send_item(rand_item(op));
    endtask

    task automatic send_power(input logic on, input logic bcast);
        tbp_pkg::item_t it;
        it = rand_item(tbp_pkg::OP_POWER_REQ);
        it.turn_on = on;
        it.from_broadcast = bcast;
        send_item(it);
    endtask

    task automatic send_packet(input logic [7:0] lead);
        tbp_pkg::item_t it;
        it = rand_item(tbp_pkg::OP_PACKET);
        it.lead_byte = lead;
        send_item(it);
    endtask

    task automatic write_limit(input logic [tbp_pkg::LIMIT_W-1:0] value);
        drain_results();
        repeat (SETTLE_CYCLES) @(negedge aclk);
        cfg_we = 1'b1;
        cfg_wdata = value;
        @(negedge aclk);
        cfg_we = 1'b0;
        board.trip_limit = value;
    endtask

    function automatic tbp_pkg::opcode_t pick_op();
        int unsigned w;
        w = $urandom_range(0, 99);
        if (w < 36)
            return tbp_pkg::OP_PULSE;
        else if (w < 50)
            return tbp_pkg::OP_WINDOW_END;
        else if (w < 60)
            return tbp_pkg::OP_PACKET;
        else if (w < 70)
            return tbp_pkg::OP_TICK;
        else if (w < 85)
            return tbp_pkg::OP_CUTOUT_TMR;
        else if (w < 91)
            return tbp_pkg::OP_READ_PEAK;
        else if (w < 97)
            return tbp_pkg::OP_POWER_REQ;
        return tbp_pkg::OP_NOP;
    endfunction

    // A session powers the track up, walks it through startup while feeding the packet
    // watchdog, then mixes pulses, windows, cutouts and the other opcodes. Some sessions starve the
    // watchdog or skip the power-up entirely.
    task automatic run_session(input int unsigned body_len);
        bit               starve;
        tbp_pkg::opcode_t op;
        int unsigned      burst;
        starve = ($urandom_range(0, 7) == 0);
        if ($urandom_range(0, 9) != 0) begin
            if (board.estop_latched || $urandom_range(0, 3) == 0)
                send_power(1'b0, 1'b0);
            send_power(1'b1, 1'b0);
            for (int t = 0; t < 64; t++) begin
                if (!starve && t % 3 == 0)
                    send_op(tbp_pkg::OP_PACKET);
                if ($urandom_range(0, 4) == 0)
                    send_op(tbp_pkg::OP_CUTOUT_TMR);
                send_op(tbp_pkg::OP_TICK);
            end
        end
        for (int n = 0; n < body_len; n++) begin
            op = pick_op();
            if (op == tbp_pkg::OP_PULSE) begin
                burst = $urandom_range(1, 10);
                repeat (burst) send_op(tbp_pkg::OP_PULSE);
            end else if (op == tbp_pkg::OP_TICK && board.powered && board.wdog_left <= 3'd1
                         && $urandom_range(0, 7) != 0) begin
                send_op(tbp_pkg::OP_PACKET);
                send_op(tbp_pkg::OP_TICK);
            end else begin
                send_op(op);
            end
        end
    endtask

    initial begin
        logic [tbp_pkg::LIMIT_W-1:0] limits [NUM_PHASES];
        int unsigned                 phase_start;

        board = new();
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tuser = '0;
        s_tdata = '0;
        limits[0] = tbp_pkg::TRIP_LIMIT_RESET;
        limits[1] = 16'd5;
        limits[2] = 16'd0;
        limits[3] = 16'hffff;
        limits[4] = tbp_pkg::LIMIT_W'($urandom_range(1, 20));

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Track not driven yet: these must all be ignored apart from the broadcast refusals.
        send_op(tbp_pkg::OP_READ_PEAK);
        send_op(tbp_pkg::OP_NOP);
        send_op(tbp_pkg::OP_WINDOW_END);
        send_packet(8'h5a);
        send_op(tbp_pkg::OP_CUTOUT_TMR);
        send_power(1'b1, 1'b1);
        send_power(1'b0, 1'b1);
        send_op(tbp_pkg::OP_PULSE);
        // Power on twice, then packets with and without a cutout.
        send_power(1'b1, 1'b0);
        send_power(1'b1, 1'b0);
        send_packet(tbp_pkg::NULL_BYTE);
        send_packet(tbp_pkg::IDLE_BYTE);
        send_packet(8'ha5);
        send_op(tbp_pkg::OP_PULSE);
        // Full cutout before startup is over must leave sensing off.
        repeat (3) send_op(tbp_pkg::OP_CUTOUT_TMR);
        // No packets: the watchdog runs out and latches emergency stop.
        repeat (4) send_op(tbp_pkg::OP_TICK);
        send_power(1'b1, 1'b0);
        drain_results();
        send_power(1'b0, 1'b0);
        send_op(tbp_pkg::OP_READ_PEAK);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            if (ph == 2) begin
                send_idle_pct = 45;
                recv_idle_pct = 20;
            end
            if (ph == 4) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (ph > 0)
                write_limit(limits[ph]);
            phase_start = sent_items;
            while (sent_items - phase_start < PHASE_ITEMS)
                run_session($urandom_range(8, 20));
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(negedge aclk);
        board.finish_check();

        $display("Run covered %0d items and %0d results with trip limits %s %0d.",
                 board.events_seen, board.results_seen, "4300, 5, 0, 65535 and",
                 limits[4]);
        $display("Seen along the way: %0d overcurrent trips, %0d emergency stops, %0d cutouts.",
                 board.trips, board.estops, board.cutouts);
        if (board.errors == 0)
            $display("track_booster_protection verification clean");
        else
            $display("track_booster_protection verification failed");
        $finish;
    end

endmodule
